FILE: hw/rtl/mesh_bounding_box_core_defines.svh
// Assertion macros shared by the mesh bounding box checker.
`ifndef MESH_BOUNDING_BOX_CORE_DEFINES_SVH
`define MESH_BOUNDING_BOX_CORE_DEFINES_SVH

// Property that must hold in the same cycle, outside reset.
`define MBB_ASSERT_NOW(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define MBB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/mbb_pkg.sv
// Shared constants and types for the mesh bounding box core.
package mbb_pkg;

    localparam int MAX_VERTICES = 65536;
    localparam int COORD_BITS   = 32;

    localparam int AXES      = 3;
    localparam int CW        = 32;   // coordinate / min / max / extent width
    localparam int SW        = 48;   // running sum width
    localparam int IN_DATA_W = AXES * CW;
    localparam int OUT_DATA_W = 3 * AXES * CW + AXES * SW;

    // Sum clamp limit: min(MAX_VERTICES * 2^(COORD_BITS-1), 2^47)
    localparam longint SUM_RAW = longint'(MAX_VERTICES) <<< (COORD_BITS - 1);
    localparam longint SUM_CAP = longint'(1) <<< 47;
    localparam longint SUM_LIM = (SUM_RAW > SUM_CAP) ? SUM_CAP : SUM_RAW;
    localparam logic signed [SW:0] SUM_MAX = (SW+1)'(SUM_LIM - 1);
    localparam logic signed [SW:0] SUM_MIN = (SW+1)'(-SUM_LIM);

    typedef struct packed {
        logic signed [CW-1:0] lo;
        logic signed [CW-1:0] hi;
        logic signed [SW-1:0] sum;
    } t_lane_res;

    // Output word, highest field first in the packed layout.
    typedef struct packed {
        logic [AXES-1:0][SW-1:0] total;
        logic [AXES-1:0][CW-1:0] extent;
        logic [AXES-1:0][CW-1:0] hi;
        logic [AXES-1:0][CW-1:0] lo;
    } t_result;

endpackage

FILE: hw/rtl/mesh_bounding_box_core.sv
// Top level of the mesh bounding box core.
//
//  channel | dir | payload                                   | sideband
//  s_axis  | in  | tdata: vert_x, vert_y, vert_z (96 bits)   | tlast: last_vertex
//  m_axis  | out | tdata: min, max, extent, total (432 bits) | none
//
// One vertex per cycle while s_axis_tready is high; three axis lanes update in parallel.
// The box of a mesh is registered in the merge stage on its last vertex, then moves on to m_axis.
// Results queue in an output register plus a skid stage; s_axis_tready drops
// only when both are full and another box is waiting in the merge stage.
// Synchronous active-low reset; the next vertex after reset starts a mesh.
module mesh_bounding_box_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // vert_x [31:0], vert_y [63:32], vert_z [95:64]
    input  logic [mbb_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // min_x, min_y, min_z, max_x, max_y, max_z, extent_x, extent_y, extent_z
    // (32 bits each, from bit 0), then total_x, total_y, total_z (48 bits each)
    output logic [mbb_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import mbb_pkg::*;

    logic                 accept;
    logic                 r_first;
    t_lane_res [AXES-1:0] lane_next;
    t_result              result;

    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else if (accept) begin
            r_first <= s_axis_tlast;
        end
    end

    for (genvar a = 0; a < AXES; a++) begin : g_lane
        mbb_lane u_lane (
            .i_clk    (i_clk),
            .i_accept (accept),
            .i_first  (r_first),
            .i_coord  (s_axis_tdata[a*CW +: CW]),
            .o_next   (lane_next[a])
        );
    end

    mbb_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept && s_axis_tlast),
        .i_lanes  (lane_next),
        .o_ready  (s_axis_tready),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    assign m_axis_tdata = result;

endmodule

FILE: hw/rtl/mbb_lane.sv
// One axis lane: running min, max and saturating sum.
module mbb_lane (
    input  logic                          i_clk,
    input  logic                          i_accept,
    input  logic                          i_first,
    input  logic [mbb_pkg::CW-1:0]        i_coord,
    output mbb_pkg::t_lane_res            o_next
);
    import mbb_pkg::*;

    logic signed [COORD_BITS-1:0] c_narrow;
    logic signed [CW-1:0]         c;
    logic signed [SW:0]           sum_wide;
    logic signed [SW-1:0]         base;
    logic signed [SW-1:0]         n_sum;
    logic signed [CW-1:0]         n_lo;
    logic signed [CW-1:0]         n_hi;

    logic signed [CW-1:0] r_lo;
    logic signed [CW-1:0] r_hi;
    logic signed [SW-1:0] r_sum;

    always_comb begin
        c_narrow = signed'(i_coord[COORD_BITS-1:0]);
        c        = CW'(c_narrow);
        base     = i_first ? '0 : r_sum;
        sum_wide = (SW+1)'(base) + (SW+1)'(c);
        if (sum_wide > SUM_MAX) begin
            n_sum = SW'(SUM_MAX);
        end else if (sum_wide < SUM_MIN) begin
            n_sum = SW'(SUM_MIN);
        end else begin
            n_sum = sum_wide[SW-1:0];
        end
        n_lo = (i_first || c < r_lo) ? c : r_lo;
        n_hi = (i_first || c > r_hi) ? c : r_hi;
    end

    // State only matters once loaded by a first vertex
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_lo  <= n_lo;
            r_hi  <= n_hi;
            r_sum <= n_sum;
        end
    end

    assign o_next.lo  = n_lo;
    assign o_next.hi  = n_hi;
    assign o_next.sum = n_sum;

endmodule

FILE: hw/rtl/mbb_merge.sv
// Merge stage: gathers lane results, forms extents, output register plus skid.
module mbb_merge (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_load,
    input  mbb_pkg::t_lane_res [mbb_pkg::AXES-1:0] i_lanes,
    output logic                                   o_ready,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output mbb_pkg::t_result                       o_result
);
    import mbb_pkg::*;

    t_lane_res [AXES-1:0] r_mid;
    logic                 r_mid_valid;
    t_result              r_out;
    logic                 r_out_valid;
    t_result              r_skid;
    logic                 r_skid_valid;

    t_result mid_res;
    logic    pop;
    logic    push;

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            mid_res.lo[a]     = r_mid[a].lo;
            mid_res.hi[a]     = r_mid[a].hi;
            mid_res.extent[a] = r_mid[a].hi - r_mid[a].lo;
            mid_res.total[a]  = r_mid[a].sum;
        end
    end

    assign pop  = r_out_valid && i_ready;
    assign push = r_mid_valid && !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_mid_valid <= 1'b1;
            end else if (push) begin
                r_mid_valid <= 1'b0;
            end

            if (!r_out_valid || pop) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= push;
                end
            end else if (push) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mid <= i_lanes;
        end
        if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (push) begin
                r_out <= mid_res;
            end
        end else if (push) begin
            r_skid <= mid_res;
        end
    end

    // Stall input only when a finished box has nowhere to go
    assign o_ready  = !(r_mid_valid && r_skid_valid);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

FILE: hw/rtl/mbb_checker.sv
// Port-level checks for the mesh bounding box core, bound to the top level.
`include "mesh_bounding_box_core_defines.svh"

module mbb_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            s_axis_tlast,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [mbb_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import mbb_pkg::*;

    logic [CW-1:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, ext_x, ext_y, ext_z;
    logic          last_xfer;
    logic          ext_ok;

    assign lo_x  = m_axis_tdata[0*CW +: CW];
    assign lo_y  = m_axis_tdata[1*CW +: CW];
    assign lo_z  = m_axis_tdata[2*CW +: CW];
    assign hi_x  = m_axis_tdata[3*CW +: CW];
    assign hi_y  = m_axis_tdata[4*CW +: CW];
    assign hi_z  = m_axis_tdata[5*CW +: CW];
    assign ext_x = m_axis_tdata[6*CW +: CW];
    assign ext_y = m_axis_tdata[7*CW +: CW];
    assign ext_z = m_axis_tdata[8*CW +: CW];

    assign last_xfer = s_axis_tvalid && s_axis_tready && s_axis_tlast;
    assign ext_ok = (ext_x == hi_x - lo_x) && (ext_y == hi_y - lo_y)
                 && (ext_z == hi_z - lo_z);

    `MBB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")
    `MBB_ASSERT_NOW(a_box_latency, $rose(m_axis_tvalid) |-> $past(last_xfer, 2),
        "box appeared without a last vertex two cycles earlier")
    `MBB_ASSERT_NOW(a_stall_cause, !s_axis_tready |-> m_axis_tvalid,
        "input stalled with no result pending")
    `MBB_ASSERT_NOW(a_extent, m_axis_tvalid |-> ext_ok,
        "extent does not match max minus min")

endmodule

bind mesh_bounding_box_core mbb_checker u_mbb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
